// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the slot pool.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock, disabled while rst is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("slot pool assertion failed");

// Same, on the block's own clock and reset.
`define ASSERT_STD(label, prop) `ASSERT_CLK(label, clock, reset, prop)

`endif

// File: hw/rtl/rcsp_pkg.sv
// Types, constants and helpers shared by the reference-counted slot pool.
`default_nettype none

package rcsp_pkg;

   localparam int SLOTS_DEF    = 16;
   localparam int KEY_BITS_DEF = 64;

   localparam int ACTION_W = 3;
   localparam int SLOT_W   = 4;
   localparam int KEY_W    = 64;
   localparam int STATUS_W = 2;
   localparam int FREE_W   = 5;
   localparam int CNT_W    = 8;

   localparam logic [CNT_W-1:0]  REF_MAX  = 8'd254;
   localparam logic [FREE_W-1:0] FREE_MAX = 5'd31;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ALLOC_UNI   = 3'd0,
      ACT_ALLOC_MULTI = 3'd1,
      ACT_REF_UP      = 3'd2,
      ACT_REF_DOWN    = 3'd3,
      ACT_FIND        = 3'd4,
      ACT_IS_USED     = 3'd5,
      ACT_SET_KEY     = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_NOFREE = 2'd1,
      ST_FAIL   = 2'd2,
      ST_INUSE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_DECODE = 2'd1,
      S_CHECK  = 2'd2
   } state_type;

   // where the next entry read takes its address from
   typedef enum logic [1:0] {
      SRC_ZERO = 2'd0,
      SRC_SLOT = 2'd1,
      SRC_NEXT = 2'd2
   } rd_src_type;

   // what kind of result the datapath registers
   typedef enum logic [1:0] {
      POST_NOFREE = 2'd0,
      POST_FAIL   = 2'd1,
      POST_HIT    = 2'd2,
      POST_EXEC   = 2'd3
   } post_type;

   typedef struct packed {
      logic       load;
      logic       rd;
      rd_src_type rd_src;
      logic       post;
      post_type   post_kind;
   } cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic is_find;
      logic is_slot_op;
      logic free_zero;
      logic slot_bad;
      logic hit;
      logic last;
      logic rsp_room;
   } stat_type;

   function automatic logic [FREE_W-1:0] free_init(input int slots);
      return (slots > 31) ? FREE_MAX : FREE_W'(slots);
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rcsp_req_if.sv
// Request channel of the slot pool: valid/ready plus action, slot and key.
`default_nettype none

interface rcsp_req_if;
   import rcsp_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [SLOT_W-1:0]   slot;
   logic [KEY_W-1:0]    key;

   modport source (output valid, action, slot, key, input ready);
   modport sink   (input valid, action, slot, key, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rcsp_rsp_if.sv
// Response channel of the slot pool: valid/ready plus status, slot and free count.
`default_nettype none

interface rcsp_rsp_if;
   import rcsp_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   out_slot;
   logic [FREE_W-1:0]   free_count;

   modport source (output valid, status, out_slot, free_count, input ready);
   modport sink   (input valid, status, out_slot, free_count, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/rcsp_dp.sv
// Slot pool datapath: slot memory, free counter, request and response registers.
`default_nettype none

module rcsp_dp #(
   parameter int SLOTS    = 16,
   parameter int KEY_BITS = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  rcsp_pkg::cmd_type              cmd,
   output rcsp_pkg::stat_type             stat,
   input  logic [rcsp_pkg::ACTION_W-1:0]  req_action,
   input  logic [rcsp_pkg::SLOT_W-1:0]    req_slot,
   input  logic [rcsp_pkg::KEY_W-1:0]     req_key,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [rcsp_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rcsp_pkg::SLOT_W-1:0]    rsp_out_slot,
   output logic [rcsp_pkg::FREE_W-1:0]    rsp_free_count
);
   import rcsp_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int EW = KEY_BITS + CNT_W;
   localparam logic [AW-1:0]        LAST_ADDR = AW'(SLOTS - 1);
   localparam logic [AW+SLOT_W-1:0] SLOTS_EXT = (AW + SLOT_W)'(SLOTS);

   // entry word: {key, count}
   logic [EW-1:0]         mem [SLOTS];
   logic [SLOTS-1:0]      vld_ff, vld_in;

   logic [ACTION_W-1:0]   act_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [KEY_BITS-1:0]   key_ff;

   logic [EW-1:0]         rd_word_ff;
   logic                  rd_vld_ff;
   logic [AW-1:0]         rd_addr_ff, rd_addr_in;

   logic [FREE_W-1:0]     free_ff, free_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [FREE_W-1:0]     rsp_free_ff;

   logic                  wr_en;
   logic [EW-1:0]         wr_data;
   logic [CNT_W-1:0]      cur_cnt;
   logic [KEY_BITS-1:0]   cur_key;
   logic [AW+SLOT_W-1:0]  slot_ext, addr_ext;
   logic                  is_alloc, is_find, is_slot_op;

   assign slot_ext = {{AW{1'b0}}, slot_ff};
   assign addr_ext = {{SLOT_W{1'b0}}, rd_addr_ff};

   // entries never written since reset read as all zero
   assign cur_cnt = rd_vld_ff ? rd_word_ff[CNT_W-1:0]  : '0;
   assign cur_key = rd_vld_ff ? rd_word_ff[EW-1:CNT_W] : '0;

   assign is_alloc   = (act_ff == ACT_ALLOC_UNI) || (act_ff == ACT_ALLOC_MULTI);
   assign is_find    = (act_ff == ACT_FIND);
   assign is_slot_op = (act_ff == ACT_REF_UP) || (act_ff == ACT_REF_DOWN) ||
                       (act_ff == ACT_IS_USED) || (act_ff == ACT_SET_KEY);

   always_comb begin
      stat            = '0;
      stat.is_alloc   = is_alloc;
      stat.is_find    = is_find;
      stat.is_slot_op = is_slot_op;
      stat.free_zero  = (free_ff == '0);
      stat.slot_bad   = (slot_ext >= SLOTS_EXT);
      stat.hit        = (is_alloc && (cur_cnt == '0)) ||
                        (is_find && (cur_cnt != '0) && (cur_key == key_ff));
      stat.last       = (rd_addr_ff == LAST_ADDR);
      stat.rsp_room   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      rd_addr_in = rd_addr_ff;
      if (cmd.rd) begin
         case (cmd.rd_src)
            SRC_ZERO: rd_addr_in = '0;
            SRC_SLOT: rd_addr_in = slot_ext[AW-1:0];
            SRC_NEXT: rd_addr_in = rd_addr_ff + AW'(1);
            default:  rd_addr_in = rd_addr_ff;
         endcase
      end
   end

   always_comb begin
      wr_en         = 1'b0;
      wr_data       = {cur_key, cur_cnt};
      free_in       = free_ff;
      rsp_status_in = ST_OK;
      rsp_slot_in   = '0;
      vld_in        = vld_ff;
      if (cmd.post) begin
         case (cmd.post_kind)
            POST_NOFREE: rsp_status_in = ST_NOFREE;
            POST_FAIL: begin
               rsp_status_in = ST_FAIL;
               // free counter said there was room but the scan found none
               if (is_alloc) free_in = '0;
            end
            POST_HIT: begin
               rsp_slot_in = addr_ext[SLOT_W-1:0];
               if (is_alloc) begin
                  wr_en   = 1'b1;
                  wr_data = {cur_key, CNT_W'(1)};
                  free_in = free_ff - FREE_W'(1);
               end
            end
            POST_EXEC: begin
               case (act_ff)
                  ACT_REF_UP: begin
                     wr_en = 1'b1;
                     if (cur_cnt < REF_MAX) wr_data = {cur_key, cur_cnt + CNT_W'(1)};
                  end
                  ACT_REF_DOWN: begin
                     if (cur_cnt != '0) begin
                        wr_en = 1'b1;
                        if (cur_cnt == CNT_W'(1)) begin
                           wr_data = '0;
                           if (free_ff != FREE_MAX) free_in = free_ff + FREE_W'(1);
                        end else begin
                           wr_data = {cur_key, cur_cnt - CNT_W'(1)};
                        end
                     end
                  end
                  ACT_IS_USED: rsp_status_in = (cur_cnt != '0) ? ST_INUSE : ST_OK;
                  ACT_SET_KEY: begin
                     wr_en   = 1'b1;
                     wr_data = {key_ff, cur_cnt};
                  end
                  default: rsp_status_in = ST_FAIL;
               endcase
            end
            default: rsp_status_in = ST_FAIL;
         endcase
      end
      if (wr_en) vld_in[rd_addr_ff] = 1'b1;
   end

   assign rsp_valid_in = cmd.post ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         free_ff      <= free_init(SLOTS);
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req_action;
         slot_ff <= req_slot;
         key_ff  <= req_key[KEY_BITS-1:0];
      end
      if (cmd.rd) begin
         rd_addr_ff <= rd_addr_in;
         rd_vld_ff  <= vld_ff[rd_addr_in];
      end
      if (cmd.post) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_free_ff   <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[rd_addr_ff] <= wr_data;
      if (cmd.rd) rd_word_ff <= mem[rd_addr_in];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_slot   = rsp_slot_ff;
   assign rsp_free_count = rsp_free_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rcsp_ctrl.sv
// Slot pool controller: sequences decode, slot reads, scans and result posting.
`default_nettype none

module rcsp_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rcsp_pkg::stat_type stat,
   output rcsp_pkg::cmd_type  cmd
);
   import rcsp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.rd_src = SRC_NEXT;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_alloc && stat.free_zero) begin
               if (stat.rsp_room) begin
                  cmd.post      = 1'b1;
                  cmd.post_kind = POST_NOFREE;
                  state_in      = S_IDLE;
               end
            end else if (stat.is_alloc || stat.is_find) begin
               cmd.rd     = 1'b1;
               cmd.rd_src = SRC_ZERO;
               state_in   = S_CHECK;
            end else if (stat.is_slot_op && !stat.slot_bad) begin
               cmd.rd     = 1'b1;
               cmd.rd_src = SRC_SLOT;
               state_in   = S_CHECK;
            end else if (stat.rsp_room) begin
               // bad slot index or undefined action
               cmd.post      = 1'b1;
               cmd.post_kind = POST_FAIL;
               state_in      = S_IDLE;
            end
         end
         S_CHECK: begin
            if (stat.is_slot_op) begin
               if (stat.rsp_room) begin
                  cmd.post      = 1'b1;
                  cmd.post_kind = POST_EXEC;
                  state_in      = S_IDLE;
               end
            end else if (stat.hit) begin
               if (stat.rsp_room) begin
                  cmd.post      = 1'b1;
                  cmd.post_kind = POST_HIT;
                  state_in      = S_IDLE;
               end
            end else if (stat.last) begin
               if (stat.rsp_room) begin
                  cmd.post      = 1'b1;
                  cmd.post_kind = POST_FAIL;
                  state_in      = S_IDLE;
               end
            end else begin
               // one slot per cycle while scanning
               cmd.rd     = 1'b1;
               cmd.rd_src = SRC_NEXT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// File: hw/rtl/refcounted_slot_pool.sv
// Sequence after acceptance: no-free and bad-slot or bad-action failures post from decode,
// slot actions read their slot entry and then post, alloc and find scan 1 to SLOTS slots.
// The scan reads one slot entry per cycle from the slot memory.
// One transaction in flight; the next is taken once the controller is back in idle after
// the result registers; a waiting result does not block it.
// Synchronous reset: slots read as free with zero key, free count = SLOTS (max 31), no clear pass.
`default_nettype none

module refcounted_slot_pool #(
   parameter int SLOTS    = rcsp_pkg::SLOTS_DEF,
   parameter int KEY_BITS = rcsp_pkg::KEY_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rcsp_req_if.sink    req_ch,
   rcsp_rsp_if.source  rsp_ch
);
   import rcsp_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   rcsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rcsp_dp #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_action     (req_ch.action),
      .req_slot       (req_ch.slot),
      .req_key        (req_ch.key),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_status     (rsp_ch.status),
      .rsp_out_slot   (rsp_ch.out_slot),
      .rsp_free_count (rsp_ch.free_count)
   );

endmodule

`default_nettype wire

// File: hw/rtl/rcsp_checker.sv
// Port-level checks for the slot pool and the bind that attaches them.
`default_nettype none
`include "assert_macros.svh"

module rcsp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rcsp_pkg::STATUS_W-1:0] rsp_status,
   input logic [rcsp_pkg::SLOT_W-1:0]   rsp_out_slot,
   input logic [rcsp_pkg::FREE_W-1:0]   rsp_free_count
);
   import rcsp_pkg::*;

   logic [STATUS_W+SLOT_W+FREE_W-1:0] rsp_word;

   assign rsp_word = {rsp_status, rsp_out_slot, rsp_free_count};

   // one transaction at a time: no new request right after one is taken
   `ASSERT_STD(a_one_in_flight, req_valid && req_ready |=> !req_ready)

   // no-free only reported with an empty counter
   `ASSERT_STD(a_nofree_empty, rsp_valid && rsp_status == ST_NOFREE |-> rsp_free_count == '0)

   // anything but ok carries slot zero
   `ASSERT_STD(a_slot_zero, rsp_valid && rsp_status != ST_OK |-> rsp_out_slot == '0)

   `ASSERT_STD(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))

endmodule

bind refcounted_slot_pool rcsp_checker u_rcsp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_out_slot   (rsp_ch.out_slot),
   .rsp_free_count (rsp_ch.free_count)
);

`default_nettype wire

// File: test/tb_refcounted_slot_pool.sv
// Testbench for the reference-counted slot pool: random and directed requests, scoreboard check.
`timescale 1ns / 100ps

module tb_refcounted_slot_pool;
   import rcsp_pkg::*;

   localparam int POOL_SLOTS = SLOTS_DEF;
   localparam int ITEMS      = 1850;
   localparam int LONG_HOLD  = 400;
   localparam int HAMMER_UPS = 258;
   // 3-bit action code that the block does not define
   localparam logic [ACTION_W-1:0] ACT_UNDEFINED = 3'd7;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] out_slot;
      logic [FREE_W-1:0] free_count;
   } pool_result_type;

   class slot_pool_scoreboard;
      logic [CNT_W-1:0]  counts [POOL_SLOTS];
      logic              types  [POOL_SLOTS];
      logic [KEY_W-1:0]  keys   [POOL_SLOTS];
      logic [FREE_W-1:0] free_cnt;
      pool_result_type   pending_results[$];
      int                errors;
      int                checked;
      int                status_hist [4];
      int                free_at_max;

      function new();
         for (int i = 0; i < POOL_SLOTS; i++) begin
            counts[i] = '0;
            types[i]  = 1'b0;
            keys[i]   = '0;
         end
         free_cnt = FREE_W'(POOL_SLOTS);
         errors = 0;
         checked = 0;
         free_at_max = 0;
         for (int i = 0; i < 4; i++) status_hist[i] = 0;
      endfunction

      function void release_entry(int s);
         counts[s] = '0;
         types[s]  = 1'b0;
         keys[s]   = '0;
         if (free_cnt < FREE_MAX) free_cnt++;
      endfunction

      // update the pool image for one accepted request and queue its response
      function void note_request(logic [ACTION_W-1:0] act, logic [SLOT_W-1:0] s,
                                 logic [KEY_W-1:0] k);
         pool_result_type r;
         int hit;
         r.status   = ST_OK;
         r.out_slot = '0;
         hit = -1;
         case (act)
            ACT_ALLOC_UNI, ACT_ALLOC_MULTI: begin
               if (free_cnt == 0) begin
                  r.status = ST_NOFREE;
               end else begin
                  for (int i = 0; i < POOL_SLOTS; i++)
                     if (hit < 0 && counts[i] == 0) hit = i;
                  if (hit < 0) begin
                     free_cnt = '0;
                     r.status = ST_FAIL;
                  end else begin
                     types[hit]  = act[0];
                     counts[hit] = 8'd1;
                     free_cnt--;
                     r.out_slot = SLOT_W'(hit);
                  end
               end
            end
            ACT_REF_UP: begin
               if (counts[s] < REF_MAX) counts[s]++;
            end
            ACT_REF_DOWN: begin
               if (counts[s] != 0) begin
                  counts[s]--;
                  if (counts[s] == 0) release_entry(s);
               end
            end
            ACT_FIND: begin
               r.status = ST_FAIL;
               for (int i = 0; i < POOL_SLOTS; i++)
                  if (hit < 0 && counts[i] > 0 && keys[i] == k) hit = i;
               if (hit >= 0) begin
                  r.status   = ST_OK;
                  r.out_slot = SLOT_W'(hit);
               end
            end
            ACT_IS_USED: begin
               r.status = (counts[s] > 0) ? ST_INUSE : ST_OK;
            end
            ACT_SET_KEY: begin
               keys[s] = k;
            end
            default: r.status = ST_FAIL;
         endcase
         r.free_count = free_cnt;
         status_hist[r.status]++;
         if (free_cnt == FREE_MAX) free_at_max++;
         pending_results.push_back(r);
      endfunction

      function void check_response(logic [STATUS_W-1:0] st, logic [SLOT_W-1:0] os,
                                   logic [FREE_W-1:0] fc);
         pool_result_type exp_r;
         checked++;
         if (pending_results.size() == 0) begin
            $error("response with none expected: status %0d slot %0d free %0d", st, os, fc);
            errors++;
            return;
         end
         exp_r = pending_results.pop_front();
         if (st !== exp_r.status) begin
            $error("status mismatch: expected %0d actual %0d", exp_r.status, st);
            errors++;
         end
         if (os !== exp_r.out_slot) begin
            $error("out_slot mismatch: expected %0d actual %0d", exp_r.out_slot, os);
            errors++;
         end
         if (fc !== exp_r.free_count) begin
            $error("free_count mismatch: expected %0d actual %0d", exp_r.free_count, fc);
            errors++;
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   rcsp_req_if req_ch ();
   rcsp_rsp_if rsp_ch ();

   refcounted_slot_pool dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   slot_pool_scoreboard sb;
   int req_idle_pct;
   int rsp_idle_pct;
   bit hold_req;
   int hold_left;
   int sent_count;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   // response side: random back-pressure plus one long hold-off on request
   initial begin
      rsp_ch.ready <= 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready)
            sb.check_response(rsp_ch.status, rsp_ch.out_slot, rsp_ch.free_count);
         if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // called in step with the clock; returns once the block has taken the request
   task automatic send_request(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] s,
                               input logic [KEY_W-1:0] k);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.slot   <= s;
      req_ch.key    <= k;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(act, s, k);
      sent_count++;
   endtask

   function automatic logic [KEY_W-1:0] random_key();
      case ($urandom_range(5))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // a slot that is in use (or free), falling back to any slot
   function automatic logic [SLOT_W-1:0] pick_slot(bit want_used);
      logic [SLOT_W-1:0] s;
      for (int tries = 0; tries < 24; tries++) begin
         s = SLOT_W'($urandom_range(POOL_SLOTS - 1));
         if ((sb.counts[s] > 0) == want_used) return s;
      end
      return SLOT_W'($urandom_range(POOL_SLOTS - 1));
   endfunction

   function automatic logic [ACTION_W-1:0] alloc_kind();
      return $urandom_range(1) ? ACT_ALLOC_MULTI : ACT_ALLOC_UNI;
   endfunction

   task automatic run_directed();
      send_request(ACT_FIND, 4'd0, '0);
      send_request(ACT_IS_USED, 4'd15, '0);
      send_request(ACT_REF_DOWN, 4'd3, '0);
      send_request(ACT_ALLOC_UNI, 4'd0, '0);
      send_request(ACT_ALLOC_MULTI, 4'd15, '1);
      send_request(ACT_SET_KEY, 4'd0, '1);
      send_request(ACT_SET_KEY, 4'd1, '0);
      send_request(ACT_FIND, 4'd0, '0);
      send_request(ACT_FIND, 4'd0, '1);
      // key written into a free slot is not found until the slot gets a reference
      send_request(ACT_SET_KEY, 4'd15, 64'h8000_0000_0000_0001);
      send_request(ACT_FIND, 4'd0, 64'h8000_0000_0000_0001);
      send_request(ACT_REF_UP, 4'd15, '0);
      send_request(ACT_FIND, 4'd0, 64'h8000_0000_0000_0001);
      send_request(ACT_IS_USED, 4'd15, '0);
      send_request(ACT_REF_DOWN, 4'd15, '0);
      send_request(ACT_FIND, 4'd0, 64'h8000_0000_0000_0001);
      send_request(ACT_REF_UP, 4'd0, '0);
      send_request(ACT_REF_DOWN, 4'd0, '0);
      send_request(ACT_REF_DOWN, 4'd0, '0);
      send_request(ACT_UNDEFINED, 4'd15, '1);
      send_request(ACT_REF_DOWN, 4'd1, '0);
   endtask

   // drive one slot into count saturation and back down to free
   task automatic run_hammer();
      logic [SLOT_W-1:0] s;
      s = SLOT_W'($urandom_range(POOL_SLOTS - 1));
      repeat (HAMMER_UPS) send_request(ACT_REF_UP, s, random_key());
      send_request(ACT_IS_USED, s, '0);
      while (sb.counts[s] != 0) send_request(ACT_REF_DOWN, s, random_key());
      send_request(ACT_REF_DOWN, s, '0);
   endtask

   task automatic run_random_sequence();
      logic [SLOT_W-1:0] s;
      int pick;
      int n;
      pick = $urandom_range(99);
      n = $urandom_range(4, 20);
      if (pick < 22) begin
         repeat (n) send_request(alloc_kind(), SLOT_W'($urandom), random_key());
      end else if (pick < 45) begin
         repeat (n) begin
            case ($urandom_range(3))
               0: send_request(ACT_SET_KEY, pick_slot(1'b1), random_key());
               1: send_request(ACT_SET_KEY, pick_slot(1'b1), sb.keys[pick_slot(1'b1)]);
               2: send_request(ACT_FIND, SLOT_W'($urandom), sb.keys[pick_slot(1'b1)]);
               default: send_request(ACT_FIND, SLOT_W'($urandom), random_key());
            endcase
         end
      end else if (pick < 63) begin
         repeat (n) begin
            if ($urandom_range(4) == 0)
               send_request(ACT_IS_USED, SLOT_W'($urandom), random_key());
            else
               send_request(ACT_REF_DOWN, pick_slot(1'b1), random_key());
         end
      end else if (pick < 73) begin
         // up/down on a free slot pushes the free counter toward its ceiling
         s = pick_slot(1'b0);
         repeat (n) begin
            send_request(ACT_REF_UP, s, random_key());
            send_request(ACT_REF_DOWN, s, random_key());
         end
      end else if (pick < 85) begin
         // phantom references leave the counter ahead of the real free slots
         repeat ($urandom_range(1, 4)) send_request(ACT_REF_UP, pick_slot(1'b0), '0);
         repeat ($urandom_range(16, 22)) send_request(alloc_kind(), SLOT_W'($urandom), '0);
      end else if (pick < 87 && sent_count < ITEMS - 600) begin
         run_hammer();
      end else begin
         repeat ($urandom_range(3, 12))
            send_request(ACT_TYPE_RAND(), SLOT_W'($urandom), {$urandom, $urandom});
      end
   endtask

   function automatic logic [ACTION_W-1:0] ACT_TYPE_RAND();
      return ACTION_W'($urandom_range(7));
   endfunction

   task automatic wait_for_drain();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      sb = new();
      req_idle_pct = 12;
      rsp_idle_pct = 58;
      hold_req = 1'b0;
      sent_count = 0;
      reset <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.action <= '0;
      req_ch.slot   <= '0;
      req_ch.key    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_hammer();
      while (sent_count < ITEMS / 3) run_random_sequence();

      // sender pause: let every outstanding response come back first
      req_ch.valid <= 1'b0;
      wait_for_drain();
      req_idle_pct = 58;
      rsp_idle_pct = 12;
      while (sent_count < 2 * ITEMS / 3) run_random_sequence();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_req = 1'b1;
      while (sent_count < ITEMS) run_random_sequence();

      req_ch.valid <= 1'b0;
      wait_for_drain();
      repeat (30) @(posedge clock);

      $display("Sent %0d requests, checked %0d responses.", sent_count, sb.checked);
      $display("Outcomes: ok %0d, no-free %0d, fail %0d, in-use %0d; free counter at 31: %0d",
               sb.status_hist[ST_OK], sb.status_hist[ST_NOFREE], sb.status_hist[ST_FAIL],
               sb.status_hist[ST_INUSE], sb.free_at_max);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
